// ===== rtl/iovi_pkg.sv =====
// iovi_pkg: shared types and constants of the interval overlap indexer
// no dependencies; used by iovi_cell and interval_overlap_indexer_unit
package iovi_pkg;

    localparam int BACK_W = 10;
    localparam int ACT_W = 12;
    localparam int CFG_W = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_BACK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_ACTIVE = 1'b1;

    localparam logic [BACK_W-1:0] BACK_MAX = 10'd1023;
    localparam logic signed [ACT_W-1:0] ACTIVE_MAX = 12'sd1024;
    localparam logic signed [ACT_W-1:0] ACTIVE_MIN = -12'sd1024;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN
    } t_state;

    // control part of the query token that runs down the cell chain
    typedef struct packed {
        logic valid;
        logic walking;
    } t_tok;

endpackage

// ===== rtl/iovi_cell.sv =====
// iovi_cell: one cell of the end store chain, holds one stored end
// and updates the passing query token; depends on iovi_pkg
module iovi_cell #(
    parameter int IW = 11,
    parameter int CB = 31,
    parameter int J = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [IW-1:0]         i_widx,
    input  logic [CB-1:0]         i_end,
    input  logic [CB-1:0]         i_start,
    input  logic [CB-1:0]         i_pstart,
    input  logic [IW-1:0]         i_lo,
    input  logic [IW-1:0]         i_idx,
    input  iovi_pkg::t_tok        i_tok,
    input  logic [IW-1:0]         i_cnt,
    input  logic [IW-1:0]         i_adv,
    output iovi_pkg::t_tok        o_tok,
    output logic [IW-1:0]         o_cnt,
    output logic [IW-1:0]         o_adv
);

    localparam logic [IW-1:0] CELL_IDX = IW'(J);

    logic [CB-1:0] r_end;
    iovi_pkg::t_tok r_tok;
    logic [IW-1:0] r_cnt;
    logic [IW-1:0] r_adv;

    iovi_pkg::t_tok n_tok;
    logic [IW-1:0] n_cnt;
    logic [IW-1:0] n_adv;
    logic in_set;

    always_ff @(posedge i_clk) begin
        if (i_we && i_widx == CELL_IDX) begin
            r_end <= i_end;
        end
    end

    always_comb begin
        in_set = CELL_IDX < i_idx;
        n_tok = i_tok;
        n_cnt = i_cnt;
        n_adv = i_adv;
        if (in_set && r_end >= i_pstart && r_end < i_start) begin
            n_cnt = i_cnt + 1'b1;
        end
        // leading run of the window whose ends do not pass the new start
        if (in_set && i_tok.walking && CELL_IDX >= i_lo) begin
            if (r_end > i_start) begin
                n_tok.walking = 1'b0;
            end else begin
                n_adv = i_adv + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
        r_cnt <= n_cnt;
        r_adv <= n_adv;
    end

    assign o_tok = r_tok;
    assign o_cnt = r_cnt;
    assign o_adv = r_adv;

endmodule

// ===== rtl/interval_overlap_indexer_unit.sv =====
// interval_overlap_indexer_unit: top level, control and result logic
// depends on iovi_pkg and iovi_cell
// one interval at a time: a new one is accepted only when idle; the first interval of a set
// skips the cell chain, any other waits for the query token to walk the whole cell chain,
// and a result waits in FIN while the previous result is still held on the output
// reset clears control, configuration and running state; stored ends and data registers are undefined until written
module interval_overlap_indexer_unit #(
    parameter int MAX_INTERVALS = 1024,
    parameter int COORD_BITS = 31
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // start_pos, end_pos, zero fill
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] i_s_tdata,
    // restart
    input  logic                      i_s_tuser,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // back_offset, active_count, zero fill
    output logic [23:0]               o_m_tdata,
    input  logic                      i_cfg_we,
    input  logic [iovi_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [iovi_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int N = MAX_INTERVALS;
    localparam int IW = $clog2(N + 1);
    localparam int CB = COORD_BITS;
    localparam int SW = IW + 14;
    localparam int LW = ((IW > iovi_pkg::BACK_W) ? IW : iovi_pkg::BACK_W) + 1;
    localparam logic [IW-1:0] N_IDX = IW'(N);

    iovi_pkg::t_state r_state, n_state;

    logic r_cfg_back;
    logic [iovi_pkg::CFG_W-1:0] r_cfg_active;

    logic [CB-1:0] r_start, r_end, r_pstart;
    logic r_first;
    logic r_launch;
    logic [IW-1:0] r_idx, r_lo;
    logic [iovi_pkg::BACK_W-1:0] r_back;
    logic signed [iovi_pkg::ACT_W-1:0] r_active;
    logic [IW-1:0] r_cnt, r_adv;

    logic r_mv;
    logic [iovi_pkg::BACK_W-1:0] r_out_back;
    logic signed [iovi_pkg::ACT_W-1:0] r_out_active;

    logic s_acc, launch, fin_go, out_free, w_we;
    logic [IW-1:0] w_widx, n_lo;
    logic [iovi_pkg::BACK_W-1:0] n_back;
    logic signed [iovi_pkg::ACT_W-1:0] n_active;
    logic signed [SW-1:0] act_sum, back_sum;

    iovi_pkg::t_tok w_tok [N+1];
    logic [IW-1:0] w_cnt [N+1];
    logic [IW-1:0] w_adv [N+1];

    assign o_s_tready = (r_state == iovi_pkg::ST_IDLE);
    assign s_acc = i_s_tvalid && o_s_tready;
    assign launch = s_acc && !(i_s_tuser || r_idx == '0);
    assign out_free = !r_mv || i_m_tready;
    assign fin_go = (r_state == iovi_pkg::ST_FIN) && out_free;
    assign w_widx = r_first ? '0 : r_idx;
    assign w_we = fin_go && (w_widx < N_IDX);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iovi_pkg::ST_IDLE: begin
                if (s_acc) begin
                    n_state = launch ? iovi_pkg::ST_WALK : iovi_pkg::ST_FIN;
                end
            end
            iovi_pkg::ST_WALK: begin
                if (w_tok[N].valid) begin
                    n_state = iovi_pkg::ST_FIN;
                end
            end
            iovi_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = iovi_pkg::ST_IDLE;
                end
            end
            default: n_state = iovi_pkg::ST_IDLE;
        endcase
    end

    // window start, clamped to the first interval of the set
    always_comb begin
        if (LW'(r_back) + LW'(1) > LW'(r_idx)) begin
            n_lo = '0;
        end else begin
            n_lo = r_idx - IW'(r_back) - 1'b1;
        end
    end

    always_comb begin
        act_sum = SW'(r_active) - $signed(SW'({1'b0, r_cnt})) + SW'(1);
        back_sum = $signed(SW'({1'b0, r_back})) - $signed(SW'({1'b0, r_adv})) + SW'(1);
        if (r_first) begin
            n_back = iovi_pkg::BACK_W'(r_cfg_back);
            n_active = (r_cfg_active > 11'd1024) ? iovi_pkg::ACTIVE_MAX
                                                 : $signed({1'b0, r_cfg_active});
        end else if (r_cnt == '0) begin
            n_back = (r_back == iovi_pkg::BACK_MAX) ? r_back : r_back + 1'b1;
            n_active = (r_active >= iovi_pkg::ACTIVE_MAX) ? iovi_pkg::ACTIVE_MAX
                                                          : r_active + 12'sd1;
        end else begin
            if (act_sum > SW'(iovi_pkg::ACTIVE_MAX)) begin
                n_active = iovi_pkg::ACTIVE_MAX;
            end else if (act_sum < SW'(iovi_pkg::ACTIVE_MIN)) begin
                n_active = iovi_pkg::ACTIVE_MIN;
            end else begin
                n_active = act_sum[iovi_pkg::ACT_W-1:0];
            end
            if (back_sum > $signed(SW'({1'b0, iovi_pkg::BACK_MAX}))) begin
                n_back = iovi_pkg::BACK_MAX;
            end else if (back_sum < 0) begin
                n_back = '0;
            end else begin
                n_back = back_sum[iovi_pkg::BACK_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iovi_pkg::ST_IDLE;
            r_cfg_back <= 1'b0;
            r_cfg_active <= '0;
            r_pstart <= '0;
            r_idx <= '0;
            r_back <= '0;
            r_active <= '0;
            r_mv <= 1'b0;
            r_first <= 1'b0;
            r_launch <= 1'b0;
        end else begin
            r_state <= n_state;
            r_launch <= launch;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    iovi_pkg::REG_FIRST_BACK: r_cfg_back <= i_cfg_data[0];
                    iovi_pkg::REG_FIRST_ACTIVE: r_cfg_active <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s_acc) begin
                r_first <= !launch;
            end
            if (fin_go) begin
                r_pstart <= r_start;
                r_back <= n_back;
                r_active <= n_active;
                r_idx <= w_we ? w_widx + 1'b1 : w_widx;
                r_mv <= 1'b1;
            end else if (i_m_tready) begin
                r_mv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_start <= i_s_tdata[CB-1:0];
            r_end <= i_s_tdata[2*CB-1:CB];
            r_lo <= n_lo;
        end
        if (r_state == iovi_pkg::ST_WALK && w_tok[N].valid) begin
            r_cnt <= w_cnt[N];
            r_adv <= w_adv[N];
        end else if (s_acc) begin
            r_cnt <= '0;
            r_adv <= '0;
        end
        if (fin_go) begin
            r_out_back <= n_back;
            r_out_active <= n_active;
        end
    end

    assign w_tok[0] = '{valid: r_launch, walking: 1'b1};
    assign w_cnt[0] = '0;
    assign w_adv[0] = '0;

    // start and window bounds are registered at acceptance, the token enters the chain in the cycle after
    for (genvar j = 0; j < N; j++) begin : g_cell
        iovi_cell #(
            .IW(IW),
            .CB(CB),
            .J (j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_we    (w_we),
            .i_widx  (w_widx),
            .i_end   (r_end),
            .i_start (r_start),
            .i_pstart(r_pstart),
            .i_lo    (r_lo),
            .i_idx   (r_idx),
            .i_tok   (w_tok[j]),
            .i_cnt   (w_cnt[j]),
            .i_adv   (w_adv[j]),
            .o_tok   (w_tok[j+1]),
            .o_cnt   (w_cnt[j+1]),
            .o_adv   (w_adv[j+1])
        );
    end

    assign o_m_tvalid = r_mv;
    assign o_m_tdata = {2'b00, r_out_active, r_out_back};

    property p_exit_in_walk;
        @(posedge i_clk) disable iff (!i_rst_n)
        w_tok[N].valid |-> r_state == iovi_pkg::ST_WALK;
    endproperty
    a_exit_in_walk: assert property (p_exit_in_walk) else $error("token exit outside walk");

    property p_idx_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= N_IDX;
    endproperty
    a_idx_bound: assert property (p_idx_bound) else $error("item index past store");

    property p_launch_walk;
        @(posedge i_clk) disable iff (!i_rst_n)
        launch |=> r_state == iovi_pkg::ST_WALK && !r_first;
    endproperty
    a_launch_walk: assert property (p_launch_walk) else $error("launch without walk");

    property p_fin_loads;
        @(posedge i_clk) disable iff (!i_rst_n)
        fin_go |=> o_m_tvalid && r_state == iovi_pkg::ST_IDLE;
    endproperty
    a_fin_loads: assert property (p_fin_loads) else $error("result not loaded");

endmodule
